/* design/mll_pkg.sv */
`timescale 1ns / 1ps
// shared types, codes and lookup functions of the music language lexer
// no dependencies; imported by the lexer top level
package mll_pkg;

  localparam int HEAD_BYTES_DEF = 8;
  localparam int LINE_BITS_DEF  = 16;

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_EQ      = 4'd1,
    ST_GT      = 4'd2,
    ST_BANG    = 4'd3,
    ST_NUM     = 4'd4,
    ST_STR     = 4'd5,
    ST_WORD    = 4'd6,
    ST_SLASH   = 4'd7,
    ST_COMMENT = 4'd8
  } scan_state_e;

  typedef enum logic [5:0] {
    TK_TEMPO      = 6'd0,
    TK_MUSICA     = 6'd1,
    TK_FACA       = 6'd2,
    TK_REPETIR    = 6'd3,
    TK_TOCAR      = 6'd4,
    TK_SE         = 6'd5,
    TK_SENAO      = 6'd6,
    TK_FIM        = 6'd7,
    TK_PAUSAR     = 6'd8,
    TK_LPAREN     = 6'd9,
    TK_RPAREN     = 6'd10,
    TK_COMMA      = 6'd11,
    TK_DOT        = 6'd12,
    TK_SEMI       = 6'd13,
    TK_COLON      = 6'd14,
    TK_PERCENT    = 6'd15,
    TK_ASSIGN     = 6'd16,
    TK_EQ         = 6'd17,
    TK_NE         = 6'd18,
    TK_LT         = 6'd19,
    TK_GT         = 6'd20,
    TK_LE         = 6'd21,
    TK_GE         = 6'd22,
    TK_PLUS       = 6'd23,
    TK_MINUS      = 6'd24,
    TK_STAR       = 6'd25,
    TK_SLASH      = 6'd26,
    TK_VAR        = 6'd27,
    TK_NOTE       = 6'd28,
    TK_NUMBER     = 6'd29,
    TK_STRING     = 6'd30,
    TK_INVALID    = 6'd31,
    TK_EOF        = 6'd32,
    TK_UNEXPECTED = 6'd33
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   token_kind;
    logic [31:0] text_first_four;
    logic [31:0] text_next_four;
    logic [7:0]  token_length;
    logic        length_overflow;
    logic [15:0] line_number;
    logic        last_of_run;
  } lex_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // one-byte symbols that complete a token on their own
  function automatic tok_kind_e sym_kind(input logic [7:0] c);
    tok_kind_e k;
    case (c)
      "+":     k = TK_PLUS;
      "-":     k = TK_MINUS;
      ";":     k = TK_SEMI;
      "*":     k = TK_STAR;
      ",":     k = TK_COMMA;
      "%":     k = TK_PERCENT;
      "(":     k = TK_LPAREN;
      ")":     k = TK_RPAREN;
      ":":     k = TK_COLON;
      ".":     k = TK_DOT;
      "<":     k = TK_LT;
      default: k = TK_INVALID;
    endcase
    return k;
  endfunction

  // word lookup; txt holds the first seven bytes, byte 0 low, zero beyond length
  // keyword literals are spelled backwards so the first letter lands in the low byte
  function automatic tok_kind_e word_kind(input logic [7:0] len, input logic [55:0] txt);
    tok_kind_e  k;
    logic [7:0] b0;
    k  = TK_INVALID;
    b0 = txt[7:0];
    if ((len == 8'd1) && (b0 >= "a") && (b0 <= "z")) begin
      k = TK_VAR;
    end else if ((len == 8'd1) && (b0 >= "A") && (b0 <= "G")) begin
      k = TK_NOTE;
    end else if ((len == 8'd2) && (txt[15:8] == "#") &&
                 ((b0 == "A") || (b0 == "C") || (b0 == "D") ||
                  (b0 == "F") || (b0 == "G"))) begin
      k = TK_NOTE;
    end else if ((len == 8'd5) && (txt == 56'("opmet"))) begin
      k = TK_TEMPO;
    end else if ((len == 8'd6) && (txt == 56'("acisum"))) begin
      k = TK_MUSICA;
    end else if ((len == 8'd4) && (txt == 56'("acaf"))) begin
      k = TK_FACA;
    end else if ((len == 8'd7) && (txt == 56'("riteper"))) begin
      k = TK_REPETIR;
    end else if ((len == 8'd5) && (txt == 56'("racot"))) begin
      k = TK_TOCAR;
    end else if ((len == 8'd2) && (txt == 56'("es"))) begin
      k = TK_SE;
    end else if ((len == 8'd5) && (txt == 56'("oanes"))) begin
      k = TK_SENAO;
    end else if ((len == 8'd3) && (txt == 56'("mif"))) begin
      k = TK_FIM;
    end else if ((len == 8'd6) && (txt == 56'("rasuap"))) begin
      k = TK_PAUSAR;
    end
    return k;
  endfunction

  function automatic lex_result_t mk_result(input tok_kind_e kind, input logic [63:0] txt,
                                            input logic [7:0] len, input logic ovf,
                                            input logic [15:0] line);
    lex_result_t r;
    r.token_kind      = kind;
    r.text_first_four = txt[31:0];
    r.text_next_four  = txt[63:32];
    r.token_length    = len;
    r.length_overflow = ovf;
    r.line_number     = line;
    r.last_of_run     = 1'b0;
    return r;
  endfunction

endpackage

/* design/mll_channels.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces of the music language lexer
// character requests in, token results out; no dependencies
interface mll_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source (output valid, output char_byte, output end_of_input, input ready);
  modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface mll_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  token_kind;
  logic [31:0] text_first_four;
  logic [31:0] text_next_four;
  logic [7:0]  token_length;
  logic        length_overflow;
  logic [15:0] line_number;
  logic        last_of_run;

  modport source (output valid, output token_kind, output text_first_four,
                  output text_next_four, output token_length, output length_overflow,
                  output line_number, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input text_first_four,
                  input text_next_four, input token_length, input length_overflow,
                  input line_number, input last_of_run, output ready);
endinterface

/* design/music_language_lexer_unit.sv */
`timescale 1ns / 1ps
// streaming lexer for a small music language, one source byte per request
// depends on mll_pkg and the channel interfaces in mll_channels.sv
//
// Each request carries one source byte or an end-of-input mark. The scanner
// state, the first HEAD_BYTES token bytes, the token length and the line
// counter live in registers; the whole decision for a byte is one short
// combinational pass from those registers and the incoming request into a
// two-slot result register. A request is taken every cycle as long as the
// second result slot is empty and the first is free or draining, so plain
// text streams at one byte per clock while results are taken; results
// appear in the cycle after the request. A byte that both closes a token
// and completes another (and every end-of-input mark while a token is
// pending) gives two results; the second waits in the second slot, which
// holds ready low until it drains. Bytes that give no result (letters inside
// a word, blanks, comment text) never touch the result slots. Tokens carry
// the line number current when they close, so a token ended by a newline
// reports the line before it. Text past HEAD_BYTES is dropped but counted,
// and the length saturates at 255. No clearing pass is needed after reset.
module music_language_lexer_unit
  import mll_pkg::*;
#(
  parameter int HEAD_BYTES = HEAD_BYTES_DEF,  // stored token bytes, 7 to 16
  parameter int LINE_BITS  = LINE_BITS_DEF    // line counter width, 8 to 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mll_in_if.sink    in_i,
  mll_out_if.source out_o
);

  localparam int HW = HEAD_BYTES * 8;

  // scanner registers
  scan_state_e          state_q, state_d;
  logic [HW-1:0]        head_q, head_d;
  logic [7:0]           count_q, count_d;
  logic [LINE_BITS-1:0] line_q, line_d;

  // result slots: slot 0 drives the port, slot 1 holds a second result
  lex_result_t out0_q, out0_d, out1_q, out1_d;
  logic        out0_vld_q, out0_vld_d, out1_vld_q, out1_vld_d;

  logic fire_in, fire_out;
  logic [7:0] c;
  logic       eoi;

  // idle-state decode of the incoming byte
  scan_state_e idle_state;
  logic        idle_push, idle_emit, idle_emit_byte, idle_nl;
  tok_kind_e   idle_kind;

  // pending-token pass
  scan_state_e st1;
  logic        push1, emit1, again, clr1, do_idle;
  tok_kind_e   kind1;
  logic [HW-1:0]      head_p;
  logic [7:0]         count_p;
  logic [HW+63:0]     ext_q, ext_p;
  logic [LINE_BITS+15:0] line_ext;
  logic [15:0]        line_now;

  lex_result_t res_a, res_b, res_pend, res_eof, res_one, res_idle;
  logic [1:0]  n_res;

  assign c        = in_i.char_byte;
  assign eoi      = in_i.end_of_input;
  assign ext_q    = {64'b0, head_q};
  assign ext_p    = {64'b0, head_p};
  assign line_ext = {16'b0, line_q};
  assign line_now = line_ext[15:0];

  // a request is taken only when both its results are sure to find a slot
  assign in_i.ready = !out1_vld_q && (!out0_vld_q || out_o.ready);
  assign fire_in    = in_i.valid && in_i.ready;
  assign fire_out   = out0_vld_q && out_o.ready;

  // what a byte does when no token is pending (text is always empty there)
  always_comb begin
    idle_state     = ST_IDLE;
    idle_push      = 1'b0;
    idle_emit      = 1'b0;
    idle_emit_byte = 1'b0;
    idle_nl        = 1'b0;
    idle_kind      = TK_INVALID;
    if (c == CH_NL) begin
      idle_nl = 1'b1;
    end else if ((c == CH_TAB) || (c == CH_SP)) begin
      idle_state = ST_IDLE;  // blanks separate tokens and are dropped
    end else if (c == "=") begin
      idle_push  = 1'b1;
      idle_state = ST_EQ;
    end else if (c == ">") begin
      idle_push  = 1'b1;
      idle_state = ST_GT;
    end else if (c == "!") begin
      idle_push  = 1'b1;
      idle_state = ST_BANG;
    end else if (is_digit(c)) begin
      idle_push  = 1'b1;
      idle_state = ST_NUM;
    end else if (c == "\"") begin
      idle_state = ST_STR;   // the opening quote is not part of the text
    end else if (is_letter(c)) begin
      idle_push  = 1'b1;
      idle_state = ST_WORD;
    end else if (c == "/") begin
      idle_push  = 1'b1;
      idle_state = ST_SLASH;
    end else if (sym_kind(c) != TK_INVALID) begin
      idle_emit      = 1'b1;
      idle_emit_byte = 1'b1;
      idle_kind      = sym_kind(c);
    end else begin
      // unknown start byte: invalid with empty text, byte consumed
      idle_emit = 1'b1;
    end
  end

  // pending token: extend it, close it, close it and rescan the byte, or drop a comment and rescan
  always_comb begin
    st1     = state_q;
    push1   = 1'b0;
    emit1   = 1'b0;
    again   = 1'b0;
    clr1    = 1'b0;
    kind1   = TK_INVALID;
    unique case (state_q)
      ST_IDLE: begin
        st1 = ST_IDLE;
      end
      ST_EQ: begin
        emit1 = 1'b1;
        st1   = ST_IDLE;
        if (c == "<") begin
          push1 = 1'b1;
          kind1 = TK_LE;
        end else if (c == "=") begin
          push1 = 1'b1;
          kind1 = TK_EQ;
        end else begin
          // this includes "=>": the bare "=" goes out and ">" is rescanned
          kind1 = TK_ASSIGN;
          again = 1'b1;
        end
      end
      ST_GT: begin
        emit1 = 1'b1;
        st1   = ST_IDLE;
        if (c == "=") begin
          push1 = 1'b1;           // ">=" is not a symbol of the language
          kind1 = TK_INVALID;
        end else begin
          kind1 = TK_GT;
          again = 1'b1;
        end
      end
      ST_BANG: begin
        emit1 = 1'b1;
        st1   = ST_IDLE;
        if (c == "=") begin
          push1 = 1'b1;
          kind1 = TK_NE;
        end else begin
          kind1 = TK_INVALID;    // lone bang, byte consumed
        end
      end
      ST_NUM: begin
        if (is_digit(c)) begin
          push1 = 1'b1;
        end else begin
          emit1 = 1'b1;
          kind1 = TK_NUMBER;
          st1   = ST_IDLE;
          again = 1'b1;
        end
      end
      ST_STR: begin
        if (c == "\"") begin
          emit1 = 1'b1;
          kind1 = TK_STRING;
          st1   = ST_IDLE;
        end else begin
          push1 = 1'b1;          // newlines inside a string are text
        end
      end
      ST_WORD: begin
        if (is_letter(c) || (c == "#")) begin
          push1 = 1'b1;
        end else begin
          emit1 = 1'b1;
          kind1 = word_kind(count_q, ext_q[55:0]);
          st1   = ST_IDLE;
          again = 1'b1;
        end
      end
      ST_SLASH: begin
        if (c == "/") begin
          push1 = 1'b1;
          st1   = ST_COMMENT;
        end else begin
          emit1 = 1'b1;
          kind1 = TK_SLASH;
          st1   = ST_IDLE;
          again = 1'b1;
        end
      end
      ST_COMMENT: begin
        if (c == CH_NL) begin
          clr1  = 1'b1;
          st1   = ST_IDLE;
          again = 1'b1;          // newline is rescanned so it is counted
        end else begin
          push1 = 1'b1;
        end
      end
      default: begin
        clr1  = 1'b1;
        st1   = ST_IDLE;
        again = 1'b1;
      end
    endcase
  end

  // byte append into the stored head, length saturating at 255
  always_comb begin
    head_p = head_q;
    for (int i = 0; i < HEAD_BYTES; i++) begin
      if (push1 && (count_q == 8'(i))) begin
        head_p[8*i +: 8] = c;
      end
    end
    count_p = (push1 && (count_q != 8'hFF)) ? count_q + 8'd1 : count_q;
  end

  assign do_idle = !eoi && ((state_q == ST_IDLE) || again);

  // candidate results
  always_comb begin
    res_eof  = mk_result(TK_EOF, 64'b0, 8'd0, 1'b0, line_now);
    res_pend = mk_result(((state_q == ST_WORD) && (count_q == 8'd3) &&
                          (ext_q[23:0] == 24'("mif"))) ? TK_FIM : TK_UNEXPECTED,
                         ext_q[63:0], count_q, count_q > 8'(HEAD_BYTES), line_now);
    res_one  = mk_result(kind1, ext_p[63:0], count_p, count_p > 8'(HEAD_BYTES), line_now);
    res_idle = mk_result(idle_kind, idle_emit_byte ? {56'b0, c} : 64'b0,
                         {7'b0, idle_emit_byte}, 1'b0, line_now);
  end

  // ordering: a closed pending token always comes before a rescan result
  always_comb begin
    res_a = res_eof;
    res_b = res_eof;
    n_res = 2'd0;
    if (eoi) begin
      if (state_q != ST_IDLE) begin
        res_a = res_pend;
        n_res = 2'd2;
      end else begin
        n_res = 2'd1;
      end
    end else if (emit1 && do_idle && idle_emit) begin
      res_a = res_one;
      res_b = res_idle;
      n_res = 2'd2;
    end else if (emit1) begin
      res_a = res_one;
      n_res = 2'd1;
    end else if (do_idle && idle_emit) begin
      res_a = res_idle;
      n_res = 2'd1;
    end
    res_a.last_of_run = (n_res == 2'd1);
    res_b.last_of_run = 1'b1;
  end

  // next scanner state
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    count_d = count_q;
    line_d  = line_q;
    if (fire_in) begin
      if (eoi) begin
        state_d = ST_IDLE;
        head_d  = '0;
        count_d = 8'd0;
      end else if (do_idle) begin
        state_d = idle_state;
        head_d  = idle_push ? {{(HW-8){1'b0}}, c} : '0;
        count_d = idle_push ? 8'd1 : 8'd0;
        if (idle_nl && (line_q != '1)) begin
          line_d = line_q + LINE_BITS'(1);
        end
      end else begin
        state_d = st1;
        head_d  = (emit1 || clr1) ? '0 : head_p;
        count_d = (emit1 || clr1) ? 8'd0 : count_p;
      end
    end
  end

  // result slots
  always_comb begin
    out0_d     = out0_q;
    out1_d     = out1_q;
    out0_vld_d = out0_vld_q;
    out1_vld_d = out1_vld_q;
    if (fire_in) begin
      out0_d     = res_a;
      out1_d     = res_b;
      out0_vld_d = (n_res != 2'd0);
      out1_vld_d = (n_res == 2'd2);
    end else if (fire_out) begin
      out0_d     = out1_q;
      out0_vld_d = out1_vld_q;
      out1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      count_q    <= 8'd0;
      line_q     <= {{(LINE_BITS-1){1'b0}}, 1'b1};
      out0_vld_q <= 1'b0;
      out1_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      count_q    <= count_d;
      line_q     <= line_d;
      out0_vld_q <= out0_vld_d;
      out1_vld_q <= out1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out0_q <= out0_d;
    out1_q <= out1_d;
  end

  assign out_o.valid           = out0_vld_q;
  assign out_o.token_kind      = out0_q.token_kind;
  assign out_o.text_first_four = out0_q.text_first_four;
  assign out_o.text_next_four  = out0_q.text_next_four;
  assign out_o.token_length    = out0_q.token_length;
  assign out_o.length_overflow = out0_q.length_overflow;
  assign out_o.line_number     = out0_q.line_number;
  assign out_o.last_of_run     = out0_q.last_of_run;

  // the second slot only ever holds the closing result of a pair
  a_slot_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out1_vld_q |-> (out0_vld_q && out1_q.last_of_run && !out0_q.last_of_run))
    else $error("second result slot out of order");

  // idle scanner never carries leftover text
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> ((count_q == 8'd0) && (head_q == '0)))
    else $error("idle scanner holds text");

  // end of input always lands in idle with a result ready
  a_eoi_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_in && eoi) |=> ((state_q == ST_IDLE) && out0_vld_q))
    else $error("end of input not flushed");

  // line counter starts at one and saturates, never wraps to zero
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q != '0)
    else $error("line counter wrapped");

endmodule

/* bench/tb_music_language_lexer_unit.sv */
`timescale 1ns / 1ps
// self-checking bench for music_language_lexer_unit: random and directed character requests
// depends on mll_pkg (codes, result type) and the channel interfaces in mll_channels.sv
module tb_music_language_lexer_unit
  import mll_pkg::*;
;

  localparam int              HEAD_BYTES = HEAD_BYTES_DEF;
  localparam logic [15:0]     LINE_MAX   = {LINE_BITS_DEF{1'b1}};
  localparam int              N_WORDS    = 27;
  localparam int              N_SYMS     = 21;

  // one queued character request plus pacing hints for the driver
  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         rush;   // no gap after this request
    bit         drain;  // hold this request until every token has come back
  } lex_request_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  mll_in_if  char_ch ();
  mll_out_if tok_ch ();

  // bench-side drivers, known from time zero
  logic       drv_valid  = 1'b0;
  logic [7:0] drv_byte   = 8'h00;
  logic       drv_end    = 1'b0;
  logic       take_ready = 1'b0;

  assign char_ch.valid        = drv_valid;
  assign char_ch.char_byte    = drv_byte;
  assign char_ch.end_of_input = drv_end;
  assign tok_ch.ready         = take_ready;

  music_language_lexer_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_ch),
    .out_o  (tok_ch)
  );

  // ---------------------------------------------------------------------------
  // token predictor: own copy of the scanner state
  // ---------------------------------------------------------------------------
  scan_state_e sc_state;
  logic [7:0]  tok_head [HEAD_BYTES];
  logic [7:0]  tok_len;
  logic [15:0] cur_line;
  lex_result_t step_tokens[$];      // tokens of the request being scanned
  lex_result_t expected_tokens[$];  // tokens still owed by the block

  // fixed spellings: keywords first, then punctuation and operators
  string word_text [N_WORDS] = '{
    "tempo", "musica", "faca", "repetir", "tocar", "se", "senao", "fim", "pausar",
    "(", ")", ",", ".", ";", ":", "%", "=", "==", "!=", "<", ">", "=<", "=>",
    "+", "-", "*", "/"
  };
  tok_kind_e word_code [N_WORDS] = '{
    TK_TEMPO, TK_MUSICA, TK_FACA, TK_REPETIR, TK_TOCAR, TK_SE, TK_SENAO, TK_FIM, TK_PAUSAR,
    TK_LPAREN, TK_RPAREN, TK_COMMA, TK_DOT, TK_SEMI, TK_COLON, TK_PERCENT, TK_ASSIGN,
    TK_EQ, TK_NE, TK_LT, TK_GT, TK_LE, TK_GE, TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH
  };

  function automatic bit digit_byte(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit letter_byte(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic void clear_text();
    for (int i = 0; i < HEAD_BYTES; i++) tok_head[i] = 8'h00;
    tok_len = 8'd0;
  endfunction

  // bytes past the stored head are dropped, the length saturates
  function automatic void push_text(logic [7:0] c);
    if (tok_len < HEAD_BYTES) tok_head[tok_len] = c;
    if (tok_len != 8'd255) tok_len = tok_len + 8'd1;
  endfunction

  function automatic bit text_is(string s);
    if (tok_len != s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++) begin
      if (tok_head[i] != s[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // kind of the pending text: variable, note, table entry or invalid
  function automatic tok_kind_e classify_text();
    logic [7:0] b0;
    b0 = tok_head[0];
    if ((tok_len == 8'd1) && (b0 >= "a") && (b0 <= "z")) return TK_VAR;
    if ((tok_len == 8'd1) && (b0 >= "A") && (b0 <= "G")) return TK_NOTE;
    if ((tok_len == 8'd2) && (tok_head[1] == "#") &&
        ((b0 == "A") || (b0 == "C") || (b0 == "D") || (b0 == "F") || (b0 == "G")))
      return TK_NOTE;
    for (int i = 0; i < N_WORDS; i++) begin
      if (text_is(word_text[i])) return word_code[i];
    end
    return TK_INVALID;
  endfunction

  // close a token with the current text and line, then clear the text
  function automatic void emit_token(tok_kind_e k);
    lex_result_t r;
    r.token_kind      = k;
    r.text_first_four = {tok_head[3], tok_head[2], tok_head[1], tok_head[0]};
    r.text_next_four  = {tok_head[7], tok_head[6], tok_head[5], tok_head[4]};
    r.token_length    = tok_len;
    r.length_overflow = (tok_len > HEAD_BYTES);
    r.line_number     = cur_line;
    r.last_of_run     = 1'b0;
    if (step_tokens.size() < 2) step_tokens.push_back(r);
    clear_text();
  endfunction

  // a byte seen from the start state
  function automatic void scan_from_idle(logic [7:0] c);
    string lone;
    bit    is_lone;
    lone    = "+-;*,%():.<";
    is_lone = 1'b0;
    for (int i = 0; i < lone.len(); i++) begin
      if (c == lone[i]) is_lone = 1'b1;
    end
    if (c == CH_NL) begin
      if (cur_line != LINE_MAX) cur_line = cur_line + 16'd1;
    end else if ((c == CH_TAB) || (c == CH_SP)) begin
      // blank, nothing to do
    end else if (c == "=") begin
      push_text(c);
      sc_state = ST_EQ;
    end else if (c == ">") begin
      push_text(c);
      sc_state = ST_GT;
    end else if (c == "!") begin
      push_text(c);
      sc_state = ST_BANG;
    end else if (digit_byte(c)) begin
      push_text(c);
      sc_state = ST_NUM;
    end else if (c == "\"") begin
      sc_state = ST_STR;  // quotes stay out of the text
    end else if (letter_byte(c)) begin
      push_text(c);
      sc_state = ST_WORD;
    end else if (c == "/") begin
      push_text(c);
      sc_state = ST_SLASH;
    end else if (is_lone) begin
      push_text(c);
      emit_token(classify_text());
    end else begin
      emit_token(TK_INVALID);  // unknown start byte, consumed with empty text
    end
  endfunction

  // one accepted request: queue the tokens that it completes
  function automatic void tokenize_request(logic [7:0] c, logic eoi);
    bit again;
    again = 1'b0;
    step_tokens.delete();
    if (eoi) begin
      if (sc_state != ST_IDLE) begin
        if ((sc_state == ST_WORD) && text_is("fim")) emit_token(TK_FIM);
        else emit_token(TK_UNEXPECTED);
      end
      clear_text();
      emit_token(TK_EOF);
      sc_state = ST_IDLE;
    end else begin
      case (sc_state)
        ST_IDLE: again = 1'b1;
        ST_EQ: begin
          if ((c == "<") || (c == "=")) push_text(c);
          else again = 1'b1;
          emit_token(classify_text());
          sc_state = ST_IDLE;
        end
        ST_GT: begin
          if (c == "=") push_text(c);
          else again = 1'b1;
          emit_token(classify_text());
          sc_state = ST_IDLE;
        end
        ST_BANG: begin
          // a lone bang is invalid and eats the byte after it
          if (c == "=") begin
            push_text(c);
            emit_token(classify_text());
          end else begin
            emit_token(TK_INVALID);
          end
          sc_state = ST_IDLE;
        end
        ST_NUM: begin
          if (digit_byte(c)) begin
            push_text(c);
          end else begin
            emit_token(TK_NUMBER);
            sc_state = ST_IDLE;
            again    = 1'b1;
          end
        end
        ST_STR: begin
          if (c == "\"") begin
            emit_token(TK_STRING);
            sc_state = ST_IDLE;
          end else begin
            push_text(c);
          end
        end
        ST_WORD: begin
          if (letter_byte(c) || (c == "#")) begin
            push_text(c);
          end else begin
            emit_token(classify_text());
            sc_state = ST_IDLE;
            again    = 1'b1;
          end
        end
        ST_SLASH: begin
          if (c == "/") begin
            push_text(c);
            sc_state = ST_COMMENT;
          end else begin
            emit_token(classify_text());
            sc_state = ST_IDLE;
            again    = 1'b1;
          end
        end
        ST_COMMENT: begin
          if (c == CH_NL) begin
            clear_text();
            sc_state = ST_IDLE;
            again    = 1'b1;
          end else begin
            push_text(c);
          end
        end
        default: begin
          clear_text();
          sc_state = ST_IDLE;
          again    = 1'b1;
        end
      endcase
      // the closing byte is scanned again from the start state
      if (again) scan_from_idle(c);
    end
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // pacing: mostly short gaps, a few long ones, and calm stretches with none
  // ---------------------------------------------------------------------------
  int send_mode_left = 0;
  bit send_calm      = 1'b0;
  int take_mode_left = 0;
  bit take_calm      = 1'b0;

  function automatic int draw_pause(inout int mode_left, inout bit calm);
    int r;
    if (mode_left == 0) begin
      calm      = ($urandom_range(0, 3) == 0);
      mode_left = $urandom_range(40, 200);
    end
    mode_left = mode_left - 1;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  lex_request_t char_requests[$];
  int           gen_items  = 0;
  int           long_runs  = 0;
  bit           drain_next = 1'b0;

  string sym_text [N_SYMS] = '{
    "(", ")", ",", ".", ";", ":", "%", "=", "==", "!=", "<", ">", "=<", "=>", ">=",
    "+", "-", "*", "/", "#", "!"
  };

  task automatic queue_item(logic [7:0] c, logic eoi, bit rush);
    lex_request_t q;
    q.ch       = c;
    q.eoi      = eoi;
    q.rush     = rush;
    q.drain    = drain_next;
    drain_next = 1'b0;
    char_requests.push_back(q);
    if (!rush) gen_items++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_item(s[i], 1'b0, 1'b0);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(65, 90));
    return 8'($urandom_range(97, 122));
  endfunction

  // text byte, mostly printable, never the given terminator
  function automatic logic [7:0] rand_text_byte(logic [7:0] stop);
    logic [7:0] b;
    do begin
      if ($urandom_range(0, 3) != 0) b = 8'($urandom_range(32, 126));
      else b = 8'($urandom_range(0, 255));
    end while (b == stop);
    return b;
  endfunction

  // one random token, mostly well formed, some noise
  task automatic queue_random_token();
    int    pick;
    int    n;
    string kw;
    pick = $urandom_range(0, 99);
    kw   = word_text[$urandom_range(0, 8)];
    if (pick < 14) begin
      queue_text(kw);
    end else if (pick < 20) begin
      // near miss of a keyword
      if ($urandom_range(0, 1) == 0) begin
        queue_text(kw);
        queue_item(($urandom_range(0, 3) == 0) ? 8'("#") : rand_letter(), 1'b0, 1'b0);
      end else begin
        queue_text(kw.substr(0, kw.len() - 2));
      end
    end else if (pick < 28) begin
      queue_item(8'($urandom_range(97, 122)), 1'b0, 1'b0);
    end else if (pick < 36) begin
      // note, sometimes a capital outside A..G, optional sharp
      if ($urandom_range(0, 3) == 0) queue_item(8'($urandom_range(65, 90)), 1'b0, 1'b0);
      else queue_item(8'($urandom_range(65, 71)), 1'b0, 1'b0);
      if ($urandom_range(0, 1) == 0) queue_item("#", 1'b0, 1'b0);
    end else if (pick < 44) begin
      n = $urandom_range(1, 12);
      repeat (n) queue_item(rand_letter(), 1'b0, 1'b0);
    end else if (pick < 47) begin
      // long runs; every tenth one goes past the length limit
      n = (long_runs % 10 == 0) ? $urandom_range(256, 262) : $urandom_range(9, 24);
      long_runs++;
      case ($urandom_range(0, 3))
        0: repeat (n) queue_item(rand_letter(), 1'b0, 1'b0);
        1: repeat (n) queue_item(8'($urandom_range(48, 57)), 1'b0, 1'b0);
        2: begin
          queue_item("\"", 1'b0, 1'b0);
          repeat (n) queue_item(rand_text_byte("\""), 1'b0, 1'b0);
          queue_item("\"", 1'b0, 1'b0);
        end
        default: begin
          queue_text("//");
          repeat (n) queue_item(rand_text_byte(CH_NL), 1'b0, 1'b0);
          queue_item(CH_NL, 1'b0, 1'b0);
        end
      endcase
    end else if (pick < 53) begin
      n = $urandom_range(1, 6);
      repeat (n) queue_item(8'($urandom_range(48, 57)), 1'b0, 1'b0);
    end else if (pick < 60) begin
      // string, newlines inside are text
      n = $urandom_range(0, 10);
      queue_item("\"", 1'b0, 1'b0);
      repeat (n) queue_item(rand_text_byte("\""), 1'b0, 1'b0);
      queue_item("\"", 1'b0, 1'b0);
    end else if (pick < 64) begin
      n = $urandom_range(0, 10);
      queue_text("//");
      repeat (n) queue_item(rand_text_byte(CH_NL), 1'b0, 1'b0);
      queue_item(CH_NL, 1'b0, 1'b0);
    end else if (pick < 80) begin
      queue_text(sym_text[$urandom_range(0, N_SYMS - 1)]);
    end else if (pick < 85) begin
      queue_item("!", 1'b0, 1'b0);
      queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end else if (pick < 95) begin
      queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end else if (pick < 98) begin
      queue_item(8'($urandom), 1'b1, 1'b0);
    end else begin
      // pending word at end of input, fim or other
      queue_text(($urandom_range(0, 1) == 0) ? "fim" : kw);
      queue_item(8'($urandom), 1'b1, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // request driver: one request per handshake, gaps after some of them
  // ---------------------------------------------------------------------------
  int           gap_left;
  lex_request_t next_req;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_byte  <= 8'h00;
      drv_end   <= 1'b0;
      gap_left  <= 0;
    end else begin
      // predict first so the tokens are owed before they can come back
      if (drv_valid && char_ch.ready) tokenize_request(drv_byte, drv_end);
      if (!drv_valid || char_ch.ready) begin
        if (gap_left != 0) begin
          gap_left  <= gap_left - 1;
          drv_valid <= 1'b0;
        end else if ((char_requests.size() != 0) &&
                     !(char_requests[0].drain && (expected_tokens.size() != 0))) begin
          next_req  = char_requests.pop_front();
          drv_valid <= 1'b1;
          drv_byte  <= next_req.ch;
          drv_end   <= next_req.eoi;
          gap_left  <= next_req.rush ? 0 : draw_pause(send_mode_left, send_calm);
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // token monitor: random back-pressure, in-order compare of every field
  // ---------------------------------------------------------------------------
  int          stall_left;
  int          pause_len;
  int          mismatches = 0;
  lex_result_t want_tok;
  lex_result_t seen_tok;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (tok_ch.valid && take_ready) begin
        seen_tok.token_kind      = tok_kind_e'(tok_ch.token_kind);
        seen_tok.text_first_four = tok_ch.text_first_four;
        seen_tok.text_next_four  = tok_ch.text_next_four;
        seen_tok.token_length    = tok_ch.token_length;
        seen_tok.length_overflow = tok_ch.length_overflow;
        seen_tok.line_number     = tok_ch.line_number;
        seen_tok.last_of_run     = tok_ch.last_of_run;
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: token kind %0d with nothing owed", $time, tok_ch.token_kind);
        end else begin
          want_tok = expected_tokens.pop_front();
          if (seen_tok !== want_tok) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: token mismatch", $time);
              $display("  expected kind %0d text %h %h len %0d ovf %0b line %0d last %0b",
                       want_tok.token_kind, want_tok.text_next_four,
                       want_tok.text_first_four, want_tok.token_length,
                       want_tok.length_overflow, want_tok.line_number,
                       want_tok.last_of_run);
              $display("  actual   kind %0d text %h %h len %0d ovf %0b line %0d last %0b",
                       tok_ch.token_kind, tok_ch.text_next_four, tok_ch.text_first_four,
                       tok_ch.token_length, tok_ch.length_overflow, tok_ch.line_number,
                       tok_ch.last_of_run);
            end
          end
        end
      end
      // may stall after a take, and now and then at random
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        take_ready <= 1'b0;
      end else begin
        pause_len = ((tok_ch.valid && take_ready) || ($urandom_range(0, 7) == 0)) ?
                    draw_pause(take_mode_left, take_calm) : 0;
        take_ready <= (pause_len == 0);
        stall_left <= (pause_len == 0) ? 0 : pause_len - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    sc_state = ST_IDLE;
    clear_text();
    cur_line = 16'd1;

    // directed: extreme bytes, bang forms, >=, =< and ==,
    // end of input after a pending >, after fim and while idle, sharp note,
    // string holding a newline
    queue_item(8'hFF, 1'b0, 1'b0);
    queue_item(8'h00, 1'b0, 1'b0);
    queue_text("!=!a>==<==>");
    queue_item(8'h00, 1'b1, 1'b0);
    queue_text("fim");
    queue_item(8'hFF, 1'b1, 1'b0);
    queue_item(8'h00, 1'b1, 1'b0);
    queue_text("C#\"\n\"");

    // random tokens with random separators; the first one waits for a drain
    drain_next = 1'b1;
    while (gen_items < 1850) begin
      if ($urandom_range(0, 99) == 0) drain_next = 1'b1;
      queue_random_token();
      case ($urandom_range(0, 9))
        4, 5:    queue_item(CH_SP, 1'b0, 1'b0);
        6:       queue_item(CH_TAB, 1'b0, 1'b0);
        7, 8:    queue_item(CH_NL, 1'b0, 1'b0);
        default: begin
          // no separator, tokens run together
        end
      endcase
    end
    queue_item(8'($urandom), 1'b1, 1'b0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((char_requests.size() != 0) || drv_valid) @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if ((mismatches == 0) && (expected_tokens.size() == 0)) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
